// File: sv/lcdnw_pkg.sv
// Package for the character LCD nibble sequencer: command codes, microcode format and program.
package lcdnw_pkg;

  // Command codes
  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_CHAR  = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_MOVE  = 3'd3;
  localparam logic [2:0] CMD_RAW   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_CHAR_WAIT  = 2'd0;
  localparam logic [1:0] REG_CMD_WAIT   = 2'd1;
  localparam logic [1:0] REG_CLEAR_WAIT = 2'd2;

  // Reset values and fixed holds, microseconds
  localparam logic [15:0] CHAR_WAIT_RST  = 16'd46;
  localparam logic [15:0] CMD_WAIT_RST   = 16'd40;
  localparam logic [15:0] CLEAR_WAIT_RST = 16'd1640;
  localparam logic [15:0] PWRUP_HOLD_US  = 16'd15000;
  localparam logic [15:0] INIT_WAIT1_US  = 16'd4100;
  localparam logic [15:0] INIT_WAIT2_US  = 16'd100;
  localparam logic [15:0] STROBE_US      = 16'd1;

  // Cursor base addresses
  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;

  // Nibble source select
  localparam logic [1:0] NIB_CONST = 2'd0;
  localparam logic [1:0] NIB_HI    = 2'd1;
  localparam logic [1:0] NIB_LO    = 2'd2;

  // Register select source
  localparam logic [1:0] RS_ZERO = 2'd0;
  localparam logic [1:0] RS_ONE  = 2'd1;
  localparam logic [1:0] RS_ITEM = 2'd2;

  // Wait source select
  localparam logic [2:0] WT_INIT1 = 3'd0;
  localparam logic [2:0] WT_INIT2 = 3'd1;
  localparam logic [2:0] WT_CHAR  = 3'd2;
  localparam logic [2:0] WT_CMD   = 3'd3;
  localparam logic [2:0] WT_CLEAR = 3'd4;
  localparam logic [2:0] WT_RAW   = 3'd5;

  // Phase counter codes within one nibble
  localparam logic [1:0] PH_SETUP  = 2'd0;
  localparam logic [1:0] PH_STROBE = 2'd1;
  localparam logic [1:0] PH_WAIT   = 2'd2;

  localparam int PC_W = 5;

  // Program entry points
  localparam logic [PC_W-1:0] PC_INIT  = 5'd0;
  localparam logic [PC_W-1:0] PC_CHAR  = 5'd15;
  localparam logic [PC_W-1:0] PC_CLEAR = 5'd17;
  localparam logic [PC_W-1:0] PC_MOVE  = 5'd21;
  localparam logic [PC_W-1:0] PC_RAW   = 5'd23;

  typedef struct packed {
    logic       single;    // one power-up hold phase instead of a nibble
    logic [1:0] nib_sel;
    logic [3:0] nib_const;
    logic [1:0] rs_sel;
    logic [2:0] wait_sel;
    logic       fin;       // last step of the command
  } uword_t;

  function automatic uword_t uw(logic [1:0] ns, logic [3:0] nc, logic [1:0] rs,
                                logic [2:0] ws, logic fin);
    uword_t w;
    w.single    = 1'b0;
    w.nib_sel   = ns;
    w.nib_const = nc;
    w.rs_sel    = rs;
    w.wait_sel  = ws;
    w.fin       = fin;
    return w;
  endfunction

  // Microprogram, one word per nibble step
  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    w = uw(NIB_CONST, 4'h0, RS_ZERO, WT_CMD, 1'b1);
    case (pc)
      5'd0: begin
        w = uw(NIB_CONST, 4'h0, RS_ZERO, WT_CMD, 1'b0);
        w.single = 1'b1;
      end
      5'd1:  w = uw(NIB_CONST, 4'h3, RS_ZERO, WT_INIT1, 1'b0);
      5'd2:  w = uw(NIB_CONST, 4'h3, RS_ZERO, WT_INIT2, 1'b0);
      5'd3:  w = uw(NIB_CONST, 4'h3, RS_ZERO, WT_CMD,   1'b0);
      5'd4:  w = uw(NIB_CONST, 4'h2, RS_ZERO, WT_CMD,   1'b0);
      5'd5:  w = uw(NIB_CONST, 4'h2, RS_ZERO, WT_CMD,   1'b0);
      5'd6:  w = uw(NIB_CONST, 4'h8, RS_ZERO, WT_CMD,   1'b0);
      5'd7:  w = uw(NIB_CONST, 4'h0, RS_ZERO, WT_CMD,   1'b0);
      5'd8:  w = uw(NIB_CONST, 4'h8, RS_ZERO, WT_CMD,   1'b0);
      5'd9:  w = uw(NIB_CONST, 4'h0, RS_ZERO, WT_CLEAR, 1'b0);
      5'd10: w = uw(NIB_CONST, 4'h1, RS_ZERO, WT_CLEAR, 1'b0);
      5'd11: w = uw(NIB_CONST, 4'h0, RS_ZERO, WT_CMD,   1'b0);
      5'd12: w = uw(NIB_CONST, 4'h6, RS_ZERO, WT_CMD,   1'b0);
      5'd13: w = uw(NIB_CONST, 4'h0, RS_ZERO, WT_CMD,   1'b0);
      5'd14: w = uw(NIB_CONST, 4'hC, RS_ZERO, WT_CMD,   1'b1);
      5'd15: w = uw(NIB_HI,    4'h0, RS_ONE,  WT_CHAR,  1'b0);
      5'd16: w = uw(NIB_LO,    4'h0, RS_ONE,  WT_CHAR,  1'b1);
      5'd17: w = uw(NIB_CONST, 4'h0, RS_ZERO, WT_CLEAR, 1'b0);
      5'd18: w = uw(NIB_CONST, 4'h1, RS_ZERO, WT_CLEAR, 1'b0);
      5'd19: w = uw(NIB_CONST, 4'h8, RS_ZERO, WT_CMD,   1'b0);
      5'd20: w = uw(NIB_CONST, 4'h0, RS_ZERO, WT_CMD,   1'b1);
      5'd21: w = uw(NIB_HI,    4'h0, RS_ZERO, WT_CMD,   1'b0);
      5'd22: w = uw(NIB_LO,    4'h0, RS_ZERO, WT_CMD,   1'b1);
      5'd23: w = uw(NIB_HI,    4'h0, RS_ITEM, WT_RAW,   1'b0);
      5'd24: w = uw(NIB_LO,    4'h0, RS_ITEM, WT_RAW,   1'b1);
      default: w = uw(NIB_CONST, 4'h0, RS_ZERO, WT_CMD, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// File: sv/char_lcd_nibble_write_sequencer_unit.sv
// Top level of the character LCD 4-bit write sequencer: microcoded nibble/phase engine.
//
//  channel  | ports                                                  | flow
//  ---------+--------------------------------------------------------+------------------------
//  command  | start, busy, in_cmd, in_data_byte, in_reg_select,      | taken when start & !busy
//           | in_wait_us, in_row, in_col                             |
//  phases   | out_valid, out_nibble, out_rs_pin, out_enable_pin,     | one-cycle strobe, no
//           | out_hold_us, out_last                                  | back-pressure
//  config   | cfg_we, cfg_index, cfg_data                            | written on cfg_we
//
// One pin phase leaves per cycle from the output register; a nibble step of the
// microprogram has three phases (setup, strobe, wait), the power-up hold one.
// An unknown command code is taken and dropped in its accept cycle.
// The next command is taken in the cycle that issues the final phase, so
// commands run back to back through the step counter with no gap.
// Reset loads the wait registers with their defaults and idles the sequencer.
module char_lcd_nibble_write_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic        in_reg_select,
  input  logic [15:0] in_wait_us,
  input  logic        in_row,
  input  logic [5:0]  in_col,
  output logic        out_valid,
  output logic [3:0]  out_nibble,
  output logic        out_rs_pin,
  output logic        out_enable_pin,
  output logic [15:0] out_hold_us,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PC_W = lcdnw_pkg::PC_W;

  // Configuration registers
  logic [15:0] char_wait_r, cmd_wait_r, clear_wait_r;

  // Sequencer state
  logic            run_r, run_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [1:0]      phase_r, phase_nxt;

  // Item operands, held for the whole command
  logic [7:0]  byte_r, byte_nxt;
  logic        rsel_r, rsel_nxt;
  logic [15:0] rwait_r, rwait_nxt;

  // Output register
  logic        ovalid_r, ovalid_nxt;
  logic [3:0]  onib_r, onib_nxt;
  logic        ors_r, ors_nxt;
  logic        oen_r, oen_nxt;
  logic [15:0] ohold_r, ohold_nxt;
  logic        olast_r, olast_nxt;

  lcdnw_pkg::uword_t cw;
  logic              step_done;
  logic              cmd_done;
  logic              accept;
  logic              cmd_ok;
  logic [PC_W-1:0]   entry_pc;
  logic [7:0]        cursor_addr;
  logic [15:0]       wait_val;

  // Fetch the control word for the current step
  assign cw        = lcdnw_pkg::ucode(pc_r);
  assign step_done = cw.single || (phase_r == lcdnw_pkg::PH_WAIT);
  assign cmd_done  = run_r && step_done && cw.fin;

  // Free while idle and in the cycle that issues the last phase
  assign busy   = run_r && !cmd_done;
  assign accept = start && !busy;

  assign cursor_addr = (in_row ? lcdnw_pkg::ROW1_BASE : lcdnw_pkg::ROW0_BASE)
                       + {2'b00, in_col};

  // Map a command code onto its program entry
  always_comb begin
    cmd_ok   = 1'b1;
    entry_pc = lcdnw_pkg::PC_INIT;
    case (in_cmd)
      lcdnw_pkg::CMD_INIT:  entry_pc = lcdnw_pkg::PC_INIT;
      lcdnw_pkg::CMD_CHAR:  entry_pc = lcdnw_pkg::PC_CHAR;
      lcdnw_pkg::CMD_CLEAR: entry_pc = lcdnw_pkg::PC_CLEAR;
      lcdnw_pkg::CMD_MOVE:  entry_pc = lcdnw_pkg::PC_MOVE;
      lcdnw_pkg::CMD_RAW:   entry_pc = lcdnw_pkg::PC_RAW;
      default:              cmd_ok   = 1'b0;
    endcase
  end

  // Select the wait time of the current step
  always_comb begin
    case (cw.wait_sel)
      lcdnw_pkg::WT_INIT1: wait_val = lcdnw_pkg::INIT_WAIT1_US;
      lcdnw_pkg::WT_INIT2: wait_val = lcdnw_pkg::INIT_WAIT2_US;
      lcdnw_pkg::WT_CHAR:  wait_val = char_wait_r;
      lcdnw_pkg::WT_CMD:   wait_val = cmd_wait_r;
      lcdnw_pkg::WT_CLEAR: wait_val = clear_wait_r;
      lcdnw_pkg::WT_RAW:   wait_val = rwait_r;
      default:             wait_val = cmd_wait_r;
    endcase
  end

  // Datapath: form the pin phase of the current step and phase
  always_comb begin
    ovalid_nxt = run_r;
    olast_nxt  = cmd_done;
    case (cw.nib_sel)
      lcdnw_pkg::NIB_HI: onib_nxt = byte_r[7:4];
      lcdnw_pkg::NIB_LO: onib_nxt = byte_r[3:0];
      default:           onib_nxt = cw.nib_const;
    endcase
    case (cw.rs_sel)
      lcdnw_pkg::RS_ONE:  ors_nxt = 1'b1;
      lcdnw_pkg::RS_ITEM: ors_nxt = rsel_r;
      default:            ors_nxt = 1'b0;
    endcase
    oen_nxt   = (phase_r == lcdnw_pkg::PH_STROBE);
    ohold_nxt = (phase_r == lcdnw_pkg::PH_WAIT) ? wait_val : lcdnw_pkg::STROBE_US;
    if (cw.single) begin
      onib_nxt  = 4'h0;
      ors_nxt   = 1'b0;
      oen_nxt   = 1'b0;
      ohold_nxt = lcdnw_pkg::PWRUP_HOLD_US;
    end
  end

  // Sequencer: advance phase, then step; load a new command on accept of a known code
  always_comb begin
    run_nxt   = run_r;
    pc_nxt    = pc_r;
    phase_nxt = phase_r;
    byte_nxt  = byte_r;
    rsel_nxt  = rsel_r;
    rwait_nxt = rwait_r;
    if (run_r) begin
      if (step_done) begin
        phase_nxt = lcdnw_pkg::PH_SETUP;
        pc_nxt    = pc_r + 1'b1;
        if (cw.fin) begin
          run_nxt = 1'b0;
        end
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
    if (accept && cmd_ok) begin
      run_nxt   = 1'b1;
      pc_nxt    = entry_pc;
      phase_nxt = lcdnw_pkg::PH_SETUP;
      byte_nxt  = (in_cmd == lcdnw_pkg::CMD_MOVE) ? cursor_addr : in_data_byte;
      rsel_nxt  = in_reg_select;
      rwait_nxt = in_wait_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= 1'b0;
      pc_r         <= '0;
      phase_r      <= lcdnw_pkg::PH_SETUP;
      ovalid_r     <= 1'b0;
      olast_r      <= 1'b0;
      char_wait_r  <= lcdnw_pkg::CHAR_WAIT_RST;
      cmd_wait_r   <= lcdnw_pkg::CMD_WAIT_RST;
      clear_wait_r <= lcdnw_pkg::CLEAR_WAIT_RST;
    end else begin
      run_r    <= run_nxt;
      pc_r     <= pc_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
      olast_r  <= olast_nxt;
      if (cfg_we) begin
        case (cfg_index)
          lcdnw_pkg::REG_CHAR_WAIT:  char_wait_r  <= cfg_data;
          lcdnw_pkg::REG_CMD_WAIT:   cmd_wait_r   <= cfg_data;
          lcdnw_pkg::REG_CLEAR_WAIT: clear_wait_r <= cfg_data;
          default: ;  // drop writes to unused indexes
        endcase
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    rsel_r  <= rsel_nxt;
    rwait_r <= rwait_nxt;
    onib_r  <= onib_nxt;
    ors_r   <= ors_nxt;
    oen_r   <= oen_nxt;
    ohold_r <= ohold_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_nibble     = onib_r;
  assign out_rs_pin     = ors_r;
  assign out_enable_pin = oen_r;
  assign out_hold_us    = ohold_r;
  assign out_last       = olast_r;

`ifndef SYNTHESIS
  a_last_valid : assert property (@(posedge clk) disable iff (!rst_n)
    olast_r |-> ovalid_r)
    else $error("last flag without a valid phase");

  a_strobe_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && oen_r) |-> (ohold_r == lcdnw_pkg::STROBE_US))
    else $error("enable strobe phase with wrong hold");

  a_strobe_then_wait : assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && oen_r) |=> (ovalid_r && !oen_r && !olast_r == 1'b0 || ovalid_r && !oen_r))
    else $error("enable strobe not followed by its wait phase");

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd_ok) |=> (run_r && phase_r == lcdnw_pkg::PH_SETUP))
    else $error("accepted command did not start its program");
`endif

endmodule

// File: test/lcd_phase_checker.sv
// Checker for the LCD nibble sequencer: predicts pin phases per command and compares them.
module lcd_phase_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic        in_reg_select,
  input  logic [15:0] in_wait_us,
  input  logic        in_row,
  input  logic [5:0]  in_col,
  input  logic        out_valid,
  input  logic [3:0]  out_nibble,
  input  logic        out_rs_pin,
  input  logic        out_enable_pin,
  input  logic [15:0] out_hold_us,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          pending
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic        en;
    logic [15:0] hold;
    logic        last;
  } pin_phase_t;

  pin_phase_t  phase_q[$];
  logic [15:0] char_wait;
  logic [15:0] cmd_wait;
  logic [15:0] clear_wait;
  int          errs;

  initial begin
    mismatch_count = 0;
    pending        = 0;
    errs           = 0;
  end

  task automatic add_phase(logic [3:0] nib, logic rs, logic en, logic [15:0] hold);
    pin_phase_t p;
    p.nibble = nib;
    p.rs     = rs;
    p.en     = en;
    p.hold   = hold;
    p.last   = 1'b0;
    phase_q.push_back(p);
  endtask

  // setup, enable strobe, then the nibble's own hold
  task automatic add_nibble(logic [3:0] nib, logic rs, logic [15:0] hold);
    add_phase(nib, rs, 1'b0, lcdnw_pkg::STROBE_US);
    add_phase(nib, rs, 1'b1, lcdnw_pkg::STROBE_US);
    add_phase(nib, rs, 1'b0, hold);
  endtask

  task automatic add_byte(logic [7:0] val, logic rs, logic [15:0] hold);
    add_nibble(val[7:4], rs, hold);
    add_nibble(val[3:0], rs, hold);
  endtask

  task automatic predict_command(logic [2:0] cmd, logic [7:0] data, logic rsel,
                                 logic [15:0] waitv, logic row, logic [5:0] col);
    int         depth;
    logic [7:0] addr;
    pin_phase_t p;
    depth = phase_q.size();
    case (cmd)
      lcdnw_pkg::CMD_INIT: begin
        add_phase(4'h0, 1'b0, 1'b0, lcdnw_pkg::PWRUP_HOLD_US);
        add_nibble(4'h3, 1'b0, lcdnw_pkg::INIT_WAIT1_US);
        add_nibble(4'h3, 1'b0, lcdnw_pkg::INIT_WAIT2_US);
        add_byte(8'h32, 1'b0, cmd_wait);
        add_byte(8'h28, 1'b0, cmd_wait);
        add_byte(8'h08, 1'b0, cmd_wait);
        add_byte(8'h01, 1'b0, clear_wait);
        add_byte(8'h06, 1'b0, cmd_wait);
        add_byte(8'h0C, 1'b0, cmd_wait);
      end
      lcdnw_pkg::CMD_CHAR:  add_byte(data, 1'b1, char_wait);
      lcdnw_pkg::CMD_CLEAR: begin
        add_byte(8'h01, 1'b0, clear_wait);
        add_byte(lcdnw_pkg::ROW0_BASE, 1'b0, cmd_wait);   // cursor home
      end
      lcdnw_pkg::CMD_MOVE: begin
        addr = (row ? lcdnw_pkg::ROW1_BASE : lcdnw_pkg::ROW0_BASE) + {2'b00, col};
        add_byte(addr, 1'b0, cmd_wait);
      end
      lcdnw_pkg::CMD_RAW:   add_byte(data, rsel, waitv);
      default: ;
    endcase
    if (phase_q.size() > depth) begin
      p = phase_q.pop_back();
      p.last = 1'b1;
      phase_q.push_back(p);
    end
  endtask

  always @(posedge clk) begin
    pin_phase_t want;
    if (!rst_n) begin
      char_wait  = lcdnw_pkg::CHAR_WAIT_RST;
      cmd_wait   = lcdnw_pkg::CMD_WAIT_RST;
      clear_wait = lcdnw_pkg::CLEAR_WAIT_RST;
      phase_q.delete();
      errs = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lcdnw_pkg::REG_CHAR_WAIT:  char_wait  = cfg_data;
          lcdnw_pkg::REG_CMD_WAIT:   cmd_wait   = cfg_data;
          lcdnw_pkg::REG_CLEAR_WAIT: clear_wait = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        predict_command(in_cmd, in_data_byte, in_reg_select, in_wait_us, in_row, in_col);
      if (out_valid) begin
        if (phase_q.size() == 0) begin
          if (errs < MAX_REPORTS)
            $display("%0t: unexpected phase nib=%h rs=%b en=%b hold=%0d last=%b", $realtime,
                     out_nibble, out_rs_pin, out_enable_pin, out_hold_us, out_last);
          errs++;
        end else begin
          want = phase_q.pop_front();
          if (out_nibble !== want.nibble || out_rs_pin !== want.rs ||
              out_enable_pin !== want.en || out_hold_us !== want.hold ||
              out_last !== want.last) begin
            if (errs < MAX_REPORTS) begin
              $write("%0t: phase mismatch exp nib=%h rs=%b en=%b hold=%0d last=%b, ",
                     $realtime, want.nibble, want.rs, want.en, want.hold, want.last);
              $display("got nib=%h rs=%b en=%b hold=%0d last=%b",
                       out_nibble, out_rs_pin, out_enable_pin, out_hold_us, out_last);
            end
            errs++;
          end
        end
      end
    end
    mismatch_count <= errs;
    pending        <= phase_q.size();
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the LCD nibble sequencer: command stimulus, wait register phases, verdict.
module tb_top;

  // Command codes the block must drop without any phase
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  // Register index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = '0;
  logic [7:0]  in_data_byte = '0;
  logic        in_reg_select = 1'b0;
  logic [15:0] in_wait_us = '0;
  logic        in_row = 1'b0;
  logic [5:0]  in_col = '0;
  logic        out_valid;
  logic [3:0]  out_nibble;
  logic        out_rs_pin;
  logic        out_enable_pin;
  logic [15:0] out_hold_us;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int mismatch_count;
  int pending;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  initial begin
    forever #2 clk = ~clk;
  end

  char_lcd_nibble_write_sequencer_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_data_byte   (in_data_byte),
    .in_reg_select  (in_reg_select),
    .in_wait_us     (in_wait_us),
    .in_row         (in_row),
    .in_col         (in_col),
    .out_valid      (out_valid),
    .out_nibble     (out_nibble),
    .out_rs_pin     (out_rs_pin),
    .out_enable_pin (out_enable_pin),
    .out_hold_us    (out_hold_us),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  lcd_phase_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_data_byte   (in_data_byte),
    .in_reg_select  (in_reg_select),
    .in_wait_us     (in_wait_us),
    .in_row         (in_row),
    .in_col         (in_col),
    .out_valid      (out_valid),
    .out_nibble     (out_nibble),
    .out_rs_pin     (out_rs_pin),
    .out_enable_pin (out_enable_pin),
    .out_hold_us    (out_hold_us),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // Watchdog: any accepted command, phase or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one command and hold it until the block takes it. Entered and left
  // right after a rising edge; start stays high across back-to-back items.
  task automatic send_cmd(logic [2:0] c, logic [7:0] d, logic rs, logic [15:0] w,
                          logic r, logic [5:0] col);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= c;
    in_data_byte  <= d;
    in_reg_select <= rs;
    in_wait_us    <= w;
    in_row        <= r;
    in_col        <= col;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start and hold off until every predicted phase has come out, then let
  // the sequencer settle in case the last command was a dropped code.
  task automatic drain_out();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy !== 1'b0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three wait registers on consecutive edges while the block is idle.
  task automatic load_waits(logic [15:0] cw, logic [15:0] mw, logic [15:0] kw, bit poke_unused);
    drain_out();
    cfg_we    <= 1'b1;
    cfg_index <= lcdnw_pkg::REG_CHAR_WAIT;
    cfg_data  <= cw;
    @(posedge clk);
    cfg_index <= lcdnw_pkg::REG_CMD_WAIT;
    cfg_data  <= mw;
    @(posedge clk);
    cfg_index <= lcdnw_pkg::REG_CLEAR_WAIT;
    cfg_data  <= kw;
    @(posedge clk);
    if (poke_unused) begin
      // the spare index must leave every wait register alone
      cfg_index <= REG_UNUSED;
      cfg_data  <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Lean toward the extremes, since hold values pass straight to the output.
  function automatic logic [15:0] pick_wait();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly character, cursor and raw writes; init is long, so keep it rare.
  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)       return lcdnw_pkg::CMD_INIT;
    else if (r < 40) return lcdnw_pkg::CMD_CHAR;
    else if (r < 50) return lcdnw_pkg::CMD_CLEAR;
    else if (r < 70) return lcdnw_pkg::CMD_MOVE;
    else if (r < 94) return lcdnw_pkg::CMD_RAW;
    else if (r < 96) return CMD_RSVD5;
    else if (r < 98) return CMD_RSVD6;
    else             return CMD_RSVD7;
  endfunction

  // Random commands with every field random, unused ones too. Idling flips on
  // and off now and then so there are long stretches without gaps as well.
  task automatic run_random(int count, bit allow_idle);
    for (int i = 0; i < count; i++) begin
      if (!allow_idle)
        idle_on = 1'b0;
      else if ($urandom_range(0, 15) == 0)
        idle_on = !idle_on;
      send_cmd(pick_cmd(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pick_wait(),
               1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands under the reset waits: every command, byte extremes,
    // cursor addresses up to 0xFF, raw writes with both RS levels, dropped codes.
    idle_on = 1'b1;
    send_cmd(lcdnw_pkg::CMD_INIT,  8'($urandom), 1'($urandom), 16'($urandom),
             1'($urandom), 6'($urandom));
    send_cmd(lcdnw_pkg::CMD_CHAR,  8'h00, 1'b0, 16'hFFFF, 1'b1, 6'h3F);
    send_cmd(lcdnw_pkg::CMD_CHAR,  8'hFF, 1'b1, 16'h0000, 1'b0, 6'h00);
    send_cmd(lcdnw_pkg::CMD_CHAR,  8'hA5, 1'b0, 16'h5A5A, 1'b1, 6'h15);
    send_cmd(lcdnw_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom),
             1'($urandom), 6'($urandom));
    send_cmd(lcdnw_pkg::CMD_MOVE,  8'hFF, 1'b1, 16'hFFFF, 1'b0, 6'h00);
    send_cmd(lcdnw_pkg::CMD_MOVE,  8'h00, 1'b0, 16'h0000, 1'b1, 6'h3F);
    send_cmd(lcdnw_pkg::CMD_MOVE,  8'h5A, 1'b1, 16'h1234, 1'b0, 6'h3F);
    send_cmd(lcdnw_pkg::CMD_MOVE,  8'hC3, 1'b0, 16'h8000, 1'b1, 6'h00);
    send_cmd(lcdnw_pkg::CMD_RAW,   8'h00, 1'b0, 16'h0000, 1'b1, 6'h2A);
    send_cmd(lcdnw_pkg::CMD_RAW,   8'hFF, 1'b1, 16'hFFFF, 1'b0, 6'h15);
    send_cmd(lcdnw_pkg::CMD_RAW,   8'h5A, 1'b1, 16'h8001, 1'b1, 6'h3F);
    send_cmd(CMD_RSVD5, 8'hFF, 1'b1, 16'hFFFF, 1'b1, 6'h3F);
    send_cmd(CMD_RSVD6, 8'h00, 1'b0, 16'h0000, 1'b0, 6'h00);
    send_cmd(CMD_RSVD7, 8'hA5, 1'b1, 16'h7FFE, 1'b0, 6'h2A);
    send_cmd(lcdnw_pkg::CMD_CHAR,  8'h3C, 1'b0, 16'h0001, 1'b0, 6'h01);
    send_cmd(lcdnw_pkg::CMD_INIT,  8'($urandom), 1'($urandom), 16'($urandom),
             1'($urandom), 6'($urandom));
    send_cmd(lcdnw_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom),
             1'($urandom), 6'($urandom));

    run_random(30, 1'b1);
    // hold off mid-phase until the pipe is empty, then carry on
    drain_out();
    run_random(10, 1'b1);

    // all waits at zero, spare index poked once
    load_waits(16'h0000, 16'h0000, 16'h0000, 1'b1);
    run_random(30, 1'b1);

    // all waits at their maximum
    load_waits(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    run_random(30, 1'b1);

    // random waits
    load_waits(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    run_random(30, 1'b1);

    // random waits again, back-to-back commands with no idling
    load_waits(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    run_random(30, 1'b0);

    drain_out();
    if (mismatch_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/lcdnw_pkg.sv
sv/char_lcd_nibble_write_sequencer_unit.sv
test/lcd_phase_checker.sv
test/tb_top.sv
